/* design/mcf_pkg.sv */
// ----------------------------------------------------------------------------
// mcf_pkg: shared types and constants for the MP3 module command framer
// Frame layout constants, the per-cell byte slot type and the checksum.
// ----------------------------------------------------------------------------
package mcf_pkg;

  localparam int unsigned FRAME_LEN = 10;

  localparam logic [7:0] START_MARK   = 8'h7E;
  localparam logic [7:0] VERSION_MARK = 8'hFF;
  localparam logic [7:0] LENGTH_MARK  = 8'h06;
  localparam logic [7:0] FEEDBACK_OFF = 8'h00;
  localparam logic [7:0] PARAM_HIGH   = 8'h00;
  localparam logic [7:0] END_MARK     = 8'hEF;

  // one byte slot of the output chain
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } cell_t;

  localparam cell_t CELL_EMPTY = '{valid: 1'b0, data: 8'h00, last: 1'b0};

  // two's complement of version + length + command + feedback + param bytes
  function automatic logic [15:0] frame_checksum(input logic [7:0] cmd,
                                                 input logic [7:0] arg);
    logic [15:0] sum;
    sum = {8'h00, VERSION_MARK} + {8'h00, LENGTH_MARK} + {8'h00, cmd}
        + {8'h00, FEEDBACK_OFF} + {8'h00, PARAM_HIGH} + {8'h00, arg};
    return 16'(16'd0 - sum);
  endfunction

endpackage

/* design/mcf_cell.sv */
// ----------------------------------------------------------------------------
// mcf_cell: one byte slot of the frame output chain
// Loads its frame byte in parallel or takes its neighbor's slot on a shift.
// ----------------------------------------------------------------------------
module mcf_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift_en,
  input  logic           load_en,
  input  mcf_pkg::cell_t load_val,
  input  mcf_pkg::cell_t next_val,
  output mcf_pkg::cell_t q
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r,  data_nxt;
  logic       last_r,  last_nxt;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    last_nxt  = last_r;
    if (load_en) begin
      valid_nxt = load_val.valid;
      data_nxt  = load_val.data;
      last_nxt  = load_val.last;
    end else if (shift_en) begin
      valid_nxt = next_val.valid;
      data_nxt  = next_val.data;
      last_nxt  = next_val.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  assign q = '{valid: valid_r, data: data_r, last: last_r};

endmodule

/* design/mp3_module_command_framer.sv */
// ----------------------------------------------------------------------------
// mp3_module_command_framer: serial command frame builder for an MP3 module
// Turns one command/argument transfer into the ten-byte player frame.
// ----------------------------------------------------------------------------
// Latency: the start byte is on out_tdata the cycle after the input transfer.
// Throughput: one byte per output transfer; the ten-cell output chain takes the
//   next command in the same cycle the end byte of the previous one leaves.
// Reset: synchronous active-low rst_n empties the chain (valid bits cleared).
module mp3_module_command_framer (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] command, [15:8] argument
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] tx_byte
  output logic        out_tlast   // frame_end
);

  localparam int unsigned N = mcf_pkg::FRAME_LEN;

  mcf_pkg::cell_t chain   [N];
  mcf_pkg::cell_t load_v  [N];
  logic [N-1:0]   vld;

  logic        shift_en;
  logic        load_en;
  logic [15:0] chk;
  logic [7:0]  cmd, arg;

  assign cmd = in_tdata[7:0];
  assign arg = in_tdata[15:8];
  assign chk = mcf_pkg::frame_checksum(cmd, arg);

  // Chain advances whenever the head is taken or empty. Bytes are packed
  // from cell 0 up, so cell 1 empty means only the head may still hold data.
  assign shift_en  = out_tready || !chain[0].valid;
  assign in_tready = !chain[1].valid && shift_en;
  assign load_en   = in_tvalid && in_tready;

  // frame bytes in transmit order; cell 0 goes out first
  always_comb begin
    load_v[0] = '{valid: 1'b1, data: mcf_pkg::START_MARK,   last: 1'b0};
    load_v[1] = '{valid: 1'b1, data: mcf_pkg::VERSION_MARK, last: 1'b0};
    load_v[2] = '{valid: 1'b1, data: mcf_pkg::LENGTH_MARK,  last: 1'b0};
    load_v[3] = '{valid: 1'b1, data: cmd,                   last: 1'b0};
    load_v[4] = '{valid: 1'b1, data: mcf_pkg::FEEDBACK_OFF, last: 1'b0};
    load_v[5] = '{valid: 1'b1, data: mcf_pkg::PARAM_HIGH,   last: 1'b0};
    load_v[6] = '{valid: 1'b1, data: arg,                   last: 1'b0};
    load_v[7] = '{valid: 1'b1, data: chk[15:8],             last: 1'b0};
    load_v[8] = '{valid: 1'b1, data: chk[7:0],              last: 1'b0};
    load_v[9] = '{valid: 1'b1, data: mcf_pkg::END_MARK,     last: 1'b1};
  end

  // each cell pulls from its upper neighbor; the top cell pulls an empty slot
  for (genvar i = 0; i < N; i++) begin : g_cell
    mcf_pkg::cell_t nbr;
    if (i == N - 1) begin : g_top
      assign nbr = mcf_pkg::CELL_EMPTY;
    end else begin : g_mid
      assign nbr = chain[i+1];
    end

    mcf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .load_en  (load_en),
      .load_val (load_v[i]),
      .next_val (nbr),
      .q        (chain[i])
    );

    assign vld[i] = chain[i].valid;
  end

  assign out_tvalid = chain[0].valid;
  assign out_tdata  = chain[0].data;
  assign out_tlast  = chain[0].last;

  // a new command always shows its start byte next cycle
  a_start_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_en |=> out_tvalid && out_tdata == mcf_pkg::START_MARK && !out_tlast)
    else $error("start byte missing after command transfer");

  // occupied cells stay packed toward the head
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (vld[N-1:1] & ~vld[N-2:0]) == '0)
    else $error("gap in output chain");

  // the end byte is the only byte left when it is at the head
  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> vld[N-1:1] == '0)
    else $error("bytes behind frame end");

  // a frame never stops short of its end byte
  a_no_truncate: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> vld[1])
    else $error("frame truncated");

endmodule

/* tb/tb_mp3_module_command_framer.sv */
// ----------------------------------------------------------------------------
// tb_mp3_module_command_framer: self-checking bench for the command framer
// Sends command/argument transfers and checks each ten-byte frame, byte by
// byte, against frames predicted here, with random idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb_mp3_module_command_framer;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_CMDS = 215;
  localparam int unsigned CALM_CMDS   = 40;    // tail of the run with no idling
  localparam int unsigned IDLE_LIMIT  = 2000;  // cycles without any transfer

  // Expected frame bytes in transmit order; each accepted command adds ten.
  class frame_checker;
    typedef struct {
      logic [7:0] tx_byte;
      logic       frame_end;
    } frame_byte_t;

    frame_byte_t pending[$];
    int unsigned failures = 0;

    function void push_byte(logic [7:0] b, logic last);
      frame_byte_t e;
      e.tx_byte   = b;
      e.frame_end = last;
      pending.push_back(e);
    endfunction

    // Builds the frame for one accepted command.
    function void note_command(logic [7:0] cmd, logic [7:0] arg);
      logic [15:0] checksum;
      // start and end markers are not part of the sum
      checksum = 16'h0000 - (16'(mcf_pkg::VERSION_MARK) + 16'(mcf_pkg::LENGTH_MARK)
                             + 16'(cmd) + 16'(mcf_pkg::FEEDBACK_OFF)
                             + 16'(mcf_pkg::PARAM_HIGH) + 16'(arg));
      push_byte(mcf_pkg::START_MARK, 1'b0);
      push_byte(mcf_pkg::VERSION_MARK, 1'b0);
      push_byte(mcf_pkg::LENGTH_MARK, 1'b0);
      push_byte(cmd, 1'b0);
      push_byte(mcf_pkg::FEEDBACK_OFF, 1'b0);
      push_byte(mcf_pkg::PARAM_HIGH, 1'b0);
      push_byte(arg, 1'b0);
      push_byte(checksum[15:8], 1'b0);
      push_byte(checksum[7:0], 1'b0);
      push_byte(mcf_pkg::END_MARK, 1'b1);
    endfunction

    function void check_byte(logic [7:0] b, logic last);
      frame_byte_t e;
      if (pending.size() == 0) begin
        $error("unexpected output transfer: tx_byte=%02h frame_end=%0b", b, last);
        failures++;
        return;
      end
      e = pending.pop_front();
      if (b !== e.tx_byte) begin
        $error("tx_byte mismatch: expected %02h, actual %02h", e.tx_byte, b);
        failures++;
      end
      if (last !== e.frame_end) begin
        $error("frame_end mismatch: expected %0b, actual %0b", e.frame_end, last);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'h0000;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  frame_checker frames = new();
  bit           calm = 1'b0;        // set for the final stretch: no idling at all
  int unsigned  ready_stall = 0;
  int unsigned  idle_cycles = 0;

  mp3_module_command_framer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: ready held low in bursts of random length, otherwise high.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (calm) begin
      ready_stall = 0;
      out_tready <= 1'b1;
    end else if (ready_stall != 0) begin
      ready_stall--;
      out_tready <= (ready_stall == 0);
    end else if ($urandom_range(0, 7) == 0) begin
      ready_stall = $urandom_range(1, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Inputs only move at the rising edge, so what is seen at the falling edge
  // is exactly what the next rising edge will take.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      frames.check_byte(out_tdata, out_tlast);
  end

  // Watchdog: a stuck handshake on either side ends the run.
  always @(negedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // One command transfer, optionally preceded by an idle burst on tvalid.
  task automatic send_command(input logic [7:0] cmd, input logic [7:0] arg);
    int unsigned gap;
    logic        taken;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {arg, cmd};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    frames.note_command(cmd, arg);
  endtask

  initial begin
    logic [7:0] cmd;
    logic [7:0] arg;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, alternating bits and typical player commands
    send_command(8'h00, 8'h00);
    send_command(8'hFF, 8'hFF);
    send_command(8'h00, 8'hFF);
    send_command(8'hFF, 8'h00);
    send_command(8'hAA, 8'h55);
    send_command(8'h55, 8'hAA);
    send_command(8'h01, 8'h80);
    send_command(8'h80, 8'h01);
    send_command(8'h03, 8'h01);    // select track
    send_command(8'h06, 8'h1E);    // volume
    send_command(8'h0D, 8'h00);    // playback
    send_command(8'h7E, 8'hEF);    // payload equal to the markers
    send_command(8'hEF, 8'h7E);
    // sum of all bytes wraps past 0x200
    send_command(8'hFE, 8'hFD);

    // random commands, half arbitrary codes, half the usual player codes
    for (int unsigned i = 0; i < RANDOM_CMDS; i++) begin
      if (i == RANDOM_CMDS - CALM_CMDS)
        calm = 1'b1;
      case ($urandom_range(0, 5))
        0:       cmd = 8'h03;
        1:       cmd = 8'h06;
        2:       cmd = 8'h0D;
        default: cmd = 8'($urandom_range(0, 255));
      endcase
      arg = 8'($urandom_range(0, 255));
      send_command(cmd, arg);
    end
    in_tvalid <= 1'b0;

    // drain, then keep clocking so the chain can show anything stray
    while (frames.pending.size() != 0)
      @(posedge clk);
    repeat (mcf_pkg::FRAME_LEN + 5) @(posedge clk);

    if (frames.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* mp3_module_command_framer.f */
design/mcf_pkg.sv
design/mcf_cell.sv
design/mp3_module_command_framer.sv
tb/tb_mp3_module_command_framer.sv
